// File: design/assert_macros.svh
// Assertion helpers shared by the RTL. Synthesis builds define SYNTH and get empty bodies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTH

// prop must hold at every clock edge outside reset
`define ASSERT_HOLDS(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed: property does not hold");

// expr must never be true outside reset
`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("assertion failed: forbidden condition seen");

`else

`define ASSERT_HOLDS(lbl, clk, rst_n, prop)
`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// File: design/cdq_pkg.sv
`timescale 1ns / 1ps

package cdq_pkg;

  localparam int DEPTH    = 16;
  localparam int IDX_W    = $clog2(DEPTH);
  localparam int CNT_W    = $clog2(DEPTH + 1);
  localparam int DATA_W   = 32;
  localparam int KIND_W   = 3;
  localparam int STATUS_W = 2;

  typedef enum logic [KIND_W-1:0] {
    K_PUSH_FRONT = 3'd0,
    K_PUSH_REAR  = 3'd1,
    K_POP_FRONT  = 3'd2,
    K_POP_REAR   = 3'd3,
    K_DUMP       = 3'd4
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  typedef enum logic {
    S_IDLE,
    S_DRAIN
  } state_t;

  // Controller -> datapath commands
  typedef struct packed {
    logic    push_front;
    logic    push_rear;
    logic    pop_front;
    logic    pop_rear;
    logic    dump_start;
    logic    load_flag;
    status_t flag_status;
    logic    load_data;
    logic    read_next;
  } cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic empty;
    logic full;
    logic drain_last;
    logic out_free;
  } stat_t;

  function automatic logic [IDX_W-1:0] wrap_inc(input logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] r;
    if (i == IDX_W'(DEPTH - 1)) begin
      r = '0;
    end else begin
      r = i + 1'b1;
    end
    return r;
  endfunction

  function automatic logic [IDX_W-1:0] wrap_dec(input logic [IDX_W-1:0] i);
    logic [IDX_W-1:0] r;
    if (i == '0) begin
      r = IDX_W'(DEPTH - 1);
    end else begin
      r = i - 1'b1;
    end
    return r;
  endfunction

endpackage

// File: design/circular_deque.sv
// circular_deque: deque of DEPTH 32-bit words in a ring RAM with registered read.
// Push, refused push and any empty report: result loaded into the output register at accept;
// a new item is taken once it is free. Pop: RAM read, then output register; no new item until
// the word is loaded. Dump of N elements: RAM read, then output register, one word per cycle
// while the output is not stalled, and no new item until the last word. Reset (rst_n low,
// synchronous) empties the deque and drops any pending result; RAM contents are not cleared.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module circular_deque import cdq_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic [KIND_W-1:0]        in_kind,
  input  logic signed [DATA_W-1:0] in_value,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [STATUS_W-1:0]      out_status,
  output logic signed [DATA_W-1:0] out_value_out,
  output logic                     out_last
);

  // Command bundle from the controller, status bundle back from the datapath.
  cmd_t  cmd;
  stat_t st;

  // Controller: accepts a transaction when idle and the result register can take a
  // new entry, then walks pops and dumps out of the RAM one word a cycle while that register is free.
  cdq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_kind  (in_kind),
    .in_ready (in_ready),
    .st       (st),
    .cmd      (cmd)
  );

  // Datapath: head/tail/occupancy, dump pointer, ring RAM and result register.
  cdq_dp u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_value      (in_value),
    .cmd           (cmd),
    .st            (st),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_status    (out_status),
    .out_value_out (out_value_out),
    .out_last      (out_last)
  );

  // Push transaction taken while the deque is full, and the single full report it yields.
  logic push_full_acc;
  logic full_report;

  assign push_full_acc = in_valid && in_ready && st.full &&
                         (in_kind == K_PUSH_FRONT || in_kind == K_PUSH_REAR);
  assign full_report   = out_valid && (out_status == ST_FULL) && out_last;

  // Never take a transaction while a stalled result would be overwritten.
  `ASSERT_HOLDS(a_no_overrun, clk, rst_n, in_ready |-> (!out_valid || out_ready))

  // Full and empty are exclusive.
  `ASSERT_NEVER(a_full_empty, clk, rst_n, st.full && st.empty)

  // A push into a full deque reports full on the next cycle as a single result.
  `ASSERT_HOLDS(a_push_full, clk, rst_n, push_full_acc |=> full_report)

endmodule

// File: design/cdq_ram.sv
`timescale 1ns / 1ps

module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// File: design/cdq_ctrl.sv
`timescale 1ns / 1ps

module cdq_ctrl import cdq_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic [KIND_W-1:0] in_kind,
  output logic              in_ready,
  input  stat_t             st,
  output cmd_t              cmd
);

  state_t state_r, state_nxt;
  logic   accept;
  kind_t  kind;

  assign kind     = kind_t'(in_kind);
  assign in_ready = (state_r == S_IDLE) && st.out_free;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && !st.empty) begin
          if (kind inside {K_POP_FRONT, K_POP_REAR, K_DUMP}) begin
            state_nxt = S_DRAIN;
          end
        end
      end
      S_DRAIN: begin
        if (st.out_free && st.drain_last) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    cmd             = '0;
    cmd.flag_status = ST_OK;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (kind)
            K_PUSH_FRONT, K_PUSH_REAR: begin
              cmd.load_flag = 1'b1;
              if (st.full) begin
                cmd.flag_status = ST_FULL;
              end else begin
                cmd.push_front = (kind == K_PUSH_FRONT);
                cmd.push_rear  = (kind == K_PUSH_REAR);
              end
            end
            K_POP_FRONT, K_POP_REAR, K_DUMP: begin
              if (st.empty) begin
                cmd.load_flag   = 1'b1;
                cmd.flag_status = ST_EMPTY;
              end else begin
                cmd.pop_front  = (kind == K_POP_FRONT);
                cmd.pop_rear   = (kind == K_POP_REAR);
                cmd.dump_start = (kind == K_DUMP);
              end
            end
            default: ;  // unknown kinds are dropped
          endcase
        end
      end
      S_DRAIN: begin
        if (st.out_free) begin
          cmd.load_data = 1'b1;
          cmd.read_next = !st.drain_last;
        end
      end
      default: ;
    endcase
  end

endmodule

// File: design/cdq_dp.sv
`timescale 1ns / 1ps

module cdq_dp import cdq_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic signed [DATA_W-1:0] in_value,
  input  cmd_t                     cmd,
  output stat_t                    st,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic [STATUS_W-1:0]      out_status,
  output logic signed [DATA_W-1:0] out_value_out,
  output logic                     out_last
);

  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic [CNT_W-1:0] occ_r, occ_nxt;
  logic [IDX_W-1:0] ptr_r, ptr_nxt;
  logic [CNT_W-1:0] left_r, left_nxt;

  logic                     ovalid_r, ovalid_nxt;
  status_t                  ostatus_r, ostatus_nxt;
  logic signed [DATA_W-1:0] ovalue_r, ovalue_nxt;
  logic                     olast_r, olast_nxt;

  logic              ram_we, ram_re;
  logic [IDX_W-1:0]  ram_waddr, ram_raddr;
  logic [DATA_W-1:0] ram_rdata;

  assign st.empty      = (occ_r == '0);
  assign st.full       = (occ_r == CNT_W'(DEPTH));
  assign st.drain_last = (left_r == CNT_W'(1));
  assign st.out_free   = !ovalid_r || out_ready;

  // Index and count bookkeeping
  always_comb begin
    head_nxt  = head_r;
    tail_nxt  = tail_r;
    occ_nxt   = occ_r;
    ptr_nxt   = ptr_r;
    left_nxt  = left_r;
    ram_waddr = '0;
    ram_raddr = ptr_r;

    if (cmd.push_front || cmd.push_rear) begin
      occ_nxt = occ_r + 1'b1;
      if (occ_r == '0) begin
        head_nxt  = '0;
        tail_nxt  = '0;
        ram_waddr = '0;
      end else if (cmd.push_front) begin
        head_nxt  = wrap_dec(head_r);
        ram_waddr = head_nxt;
      end else begin
        tail_nxt  = wrap_inc(tail_r);
        ram_waddr = tail_nxt;
      end
    end

    if (cmd.pop_front || cmd.pop_rear) begin
      occ_nxt  = occ_r - 1'b1;
      left_nxt = CNT_W'(1);
      if (cmd.pop_front) begin
        ram_raddr = head_r;
        head_nxt  = wrap_inc(head_r);
      end else begin
        ram_raddr = tail_r;
        tail_nxt  = wrap_dec(tail_r);
      end
      if (occ_r == CNT_W'(1)) begin
        head_nxt = '0;
        tail_nxt = '0;
      end
    end

    if (cmd.dump_start) begin
      ram_raddr = head_r;
      ptr_nxt   = wrap_inc(head_r);
      left_nxt  = occ_r;
    end

    if (cmd.read_next) begin
      ram_raddr = ptr_r;
      ptr_nxt   = wrap_inc(ptr_r);
      left_nxt  = left_r - 1'b1;
    end
  end

  assign ram_we = cmd.push_front || cmd.push_rear;
  assign ram_re = cmd.pop_front || cmd.pop_rear || cmd.dump_start || cmd.read_next;

  // Output register
  always_comb begin
    ovalid_nxt  = ovalid_r;
    ostatus_nxt = ostatus_r;
    ovalue_nxt  = ovalue_r;
    olast_nxt   = olast_r;
    if (cmd.load_flag) begin
      ovalid_nxt  = 1'b1;
      ostatus_nxt = cmd.flag_status;
      ovalue_nxt  = '0;
      olast_nxt   = 1'b1;
    end else if (cmd.load_data) begin
      ovalid_nxt  = 1'b1;
      ostatus_nxt = ST_OK;
      ovalue_nxt  = signed'(ram_rdata);
      olast_nxt   = st.drain_last;
    end else if (out_ready) begin
      ovalid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r   <= '0;
      tail_r   <= '0;
      occ_r    <= '0;
      ptr_r    <= '0;
      left_r   <= '0;
      ovalid_r <= 1'b0;
    end else begin
      head_r   <= head_nxt;
      tail_r   <= tail_nxt;
      occ_r    <= occ_nxt;
      ptr_r    <= ptr_nxt;
      left_r   <= left_nxt;
      ovalid_r <= ovalid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ostatus_r <= ostatus_nxt;
    ovalue_r  <= ovalue_nxt;
    olast_r   <= olast_nxt;
  end

  cdq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_value),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign out_valid     = ovalid_r;
  assign out_status    = ostatus_r;
  assign out_value_out = ovalue_r;
  assign out_last      = olast_r;

endmodule
